// ===== hw/rtl/color_line_follow_pd_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Color line follower PD controller assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef COLOR_LINE_FOLLOW_PD_CONTROLLER_TOP_MACROS_SVH
`define COLOR_LINE_FOLLOW_PD_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLFPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clfpd assertion failed");

// Next-cycle implication, disabled during reset.
`define CLFPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clfpd assertion failed");

`endif

// ===== hw/rtl/clfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Color line follower PD controller package
// Word types, register indexes, surface classes and classification windows.
// ----------------------------------------------------------------------------
`default_nettype none

package clfpd_pkg;

  localparam int PeriodW  = 14;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  typedef struct packed {
    logic [PeriodW-1:0] red_period;
    logic [PeriodW-1:0] green_period;
    logic [PeriodW-1:0] blue_period;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        left_speed;
    logic [7:0]        right_speed;
    logic              halted;
    logic [1:0]        surface_class;
    logic signed [7:0] steer_error;
  } out_word_t;

  localparam logic [CfgIdxW-1:0] CfgKp      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKd      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBase    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMax     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgConfirm = 3'd4;

  localparam logic [5:0] KpReset      = 6'd7;
  localparam logic [5:0] KdReset      = 6'd4;
  localparam logic [7:0] BaseReset    = 8'd100;
  localparam logic [7:0] MaxReset     = 8'd200;
  localparam logic [7:0] ConfirmReset = 8'd5;

  localparam logic [1:0] ClsBlack = 2'd0;
  localparam logic [1:0] ClsRed   = 2'd1;
  localparam logic [1:0] ClsBlue  = 2'd2;
  localparam logic [1:0] ClsOther = 2'd3;

  localparam logic [PeriodW-1:0] BlkRLo = 14'd135;
  localparam logic [PeriodW-1:0] BlkRHi = 14'd165;
  localparam logic [PeriodW-1:0] BlkGLo = 14'd135;
  localparam logic [PeriodW-1:0] BlkGHi = 14'd170;
  localparam logic [PeriodW-1:0] BlkBLo = 14'd130;
  localparam logic [PeriodW-1:0] BlkBHi = 14'd150;
  localparam logic [PeriodW-1:0] RedRLo = 14'd23;
  localparam logic [PeriodW-1:0] RedRHi = 14'd26;
  localparam logic [PeriodW-1:0] RedGLo = 14'd95;
  localparam logic [PeriodW-1:0] RedGHi = 14'd110;
  localparam logic [PeriodW-1:0] RedBLo = 14'd75;
  localparam logic [PeriodW-1:0] RedBHi = 14'd85;
  localparam logic [PeriodW-1:0] BluRLo = 14'd76;
  localparam logic [PeriodW-1:0] BluRHi = 14'd81;
  localparam logic [PeriodW-1:0] BluGLo = 14'd48;
  localparam logic [PeriodW-1:0] BluGHi = 14'd51;
  localparam logic [PeriodW-1:0] BluBLo = 14'd27;
  localparam logic [PeriodW-1:0] BluBHi = 14'd30;

  // Green offset and the error denominators (200/84 = 50/21, 200/132 = 50/33).
  localparam logic [PeriodW-1:0] GreenOffset = 14'd18;
  localparam logic [PeriodW-1:0] DivRed      = 14'd84;
  localparam logic [PeriodW-1:0] DivOther    = 14'd132;
  localparam int                 RecipShift  = 17;
  localparam logic [12:0]        RecipRed    = 13'd6242;
  localparam logic [12:0]        RecipOther  = 13'd3972;

  function automatic logic in_win_f(logic [PeriodW-1:0] v, logic [PeriodW-1:0] lo,
                                    logic [PeriodW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/color_line_follow_pd_controller_top.sv =====
// ----------------------------------------------------------------------------
// Color line follower PD controller
// Stages: input word, class and error, then motor word registers.
// Throughput: one word per cycle unless stalled; PD state loop in last stage.
// Reset: synchronous active low; clears state and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module color_line_follow_pd_controller_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  clfpd_pkg::in_word_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output clfpd_pkg::out_word_t                 out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [clfpd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [clfpd_pkg::CfgDataW-1:0]       cfg_data
);
  import clfpd_pkg::*;

  logic [5:0] kp_r, kd_r;
  logic [7:0] base_r, max_r, confirm_r;

  logic        s1_valid_r, s2_valid_r, out_valid_r;
  in_word_t    s1_word_r;
  logic [1:0]  s2_cls_r;
  logic signed [7:0] s2_err_r;
  out_word_t   out_word_r;

  logic signed [7:0] prev_err_r;
  logic [7:0]        blue_cnt_r;
  logic              stop_r;

  logic s1_adv, s2_adv;

  logic [1:0]         cls_nxt;
  logic [PeriodW-1:0] diff_g;
  logic [7:0]         dn;
  logic [12:0]        scaled;
  logic [12:0]        recip;
  logic [25:0]        prod;
  logic [7:0]         quot;
  logic signed [8:0]  err9;
  logic signed [7:0]  err_nxt;

  logic              blue;
  logic [7:0]        cnt_inc;
  logic [7:0]        blue_cnt_nxt;
  logic              stop_nxt;
  logic signed [8:0]  err_diff;
  logic signed [15:0] p_term, d_term, pd;
  logic signed [16:0] base2, l2, r2;
  logic [15:0]        lh, rh;
  logic [7:0]         left_spd, right_spd;
  out_word_t          out_word_nxt;

  assign s2_adv    = !out_valid_r || out_ready;
  assign s1_adv    = !s2_valid_r || s2_adv;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= KpReset;
      kd_r      <= KdReset;
      base_r    <= BaseReset;
      max_r     <= MaxReset;
      confirm_r <= ConfirmReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgKp:      kp_r      <= cfg_data[5:0];
        CfgKd:      kd_r      <= cfg_data[5:0];
        CfgBase:    base_r    <= cfg_data;
        CfgMax:     max_r     <= cfg_data;
        CfgConfirm: confirm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_win_f(s1_word_r.red_period, BlkRLo, BlkRHi) &&
        in_win_f(s1_word_r.green_period, BlkGLo, BlkGHi) &&
        in_win_f(s1_word_r.blue_period, BlkBLo, BlkBHi)) begin
      cls_nxt = ClsBlack;
    end else if (in_win_f(s1_word_r.red_period, RedRLo, RedRHi) &&
                 in_win_f(s1_word_r.green_period, RedGLo, RedGHi) &&
                 in_win_f(s1_word_r.blue_period, RedBLo, RedBHi)) begin
      cls_nxt = ClsRed;
    end else if (in_win_f(s1_word_r.red_period, BluRLo, BluRHi) &&
                 in_win_f(s1_word_r.green_period, BluGLo, BluGHi) &&
                 in_win_f(s1_word_r.blue_period, BluBLo, BluBHi)) begin
      cls_nxt = ClsBlue;
    end else begin
      cls_nxt = ClsOther;
    end
  end

  // Between the offset and the denominator, the quotient 200*d/D is taken
  // by a reciprocal multiply; outside that span the error saturates.
  always_comb begin
    diff_g = s1_word_r.green_period - GreenOffset;
    dn     = diff_g[7:0];
    scaled = {dn, 5'b0} + 13'({dn, 4'b0}) + 13'({dn, 1'b0});
    recip  = (cls_nxt == ClsRed) ? RecipRed : RecipOther;
    prod   = 26'(scaled) * 26'(recip);
    quot   = prod[RecipShift+7:RecipShift];
    err9   = 9'sd100 - $signed({1'b0, quot});
    if (s1_word_r.green_period <= GreenOffset) begin
      err_nxt = 8'sd100;
    end else if (diff_g >= ((cls_nxt == ClsRed) ? DivRed : DivOther)) begin
      err_nxt = -8'sd100;
    end else begin
      err_nxt = err9[7:0];
    end
  end

  always_comb begin
    blue    = (s2_cls_r == ClsBlue);
    cnt_inc = (blue_cnt_r == 8'hFF) ? 8'hFF : blue_cnt_r + 8'd1;
    if (stop_r) begin
      blue_cnt_nxt = blue_cnt_r;
      stop_nxt     = 1'b1;
    end else if (blue) begin
      blue_cnt_nxt = cnt_inc;
      stop_nxt     = (cnt_inc >= confirm_r);
    end else begin
      blue_cnt_nxt = 8'd0;
      stop_nxt     = 1'b0;
    end

    err_diff = 9'(s2_err_r) - 9'(prev_err_r);
    p_term   = $signed(16'(kp_r)) * 16'(s2_err_r);
    d_term   = $signed(16'(kd_r)) * 16'(err_diff);
    pd       = p_term + d_term;
    base2    = $signed(17'({base_r, 1'b0}));
    l2       = base2 - 17'(pd);
    r2       = base2 + 17'(pd);
    lh       = l2[16:1];
    rh       = r2[16:1];
    if (l2 < 0) begin
      left_spd = 8'd0;
    end else if (lh > 16'(max_r)) begin
      left_spd = max_r;
    end else begin
      left_spd = lh[7:0];
    end
    if (r2 < 0) begin
      right_spd = 8'd0;
    end else if (rh > 16'(max_r)) begin
      right_spd = max_r;
    end else begin
      right_spd = rh[7:0];
    end

    out_word_nxt.surface_class = s2_cls_r;
    if (stop_nxt) begin
      out_word_nxt.left_speed  = 8'd0;
      out_word_nxt.right_speed = 8'd0;
      out_word_nxt.halted      = 1'b1;
      out_word_nxt.steer_error = 8'sd0;
    end else begin
      out_word_nxt.left_speed  = left_spd;
      out_word_nxt.right_speed = right_spd;
      out_word_nxt.halted      = 1'b0;
      out_word_nxt.steer_error = s2_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prev_err_r  <= 8'sd0;
      blue_cnt_r  <= 8'd0;
      stop_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_adv) begin
        out_valid_r <= s2_valid_r;
      end
      if (s2_adv && s2_valid_r) begin
        blue_cnt_r <= blue_cnt_nxt;
        stop_r     <= stop_nxt;
        if (!stop_nxt) begin
          prev_err_r <= s2_err_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
    if (s1_adv) begin
      s2_cls_r <= cls_nxt;
      s2_err_r <= err_nxt;
    end
    if (s2_adv && s2_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/clfpd_checker.sv =====
// ----------------------------------------------------------------------------
// Color line follower PD controller checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_line_follow_pd_controller_top_macros.svh"

module clfpd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input clfpd_pkg::out_word_t out_data
);
  import clfpd_pkg::*;

  logic seen_halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && out_data.halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  `CLFPD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CLFPD_ASSERT_IMP(a_halt_zero, clk, rst_n, out_valid && out_data.halted, (out_data.left_speed == 8'd0) && (out_data.right_speed == 8'd0) && (out_data.steer_error == 8'sd0))
  `CLFPD_ASSERT_IMP(a_halt_sticky, clk, rst_n, out_valid && seen_halt_r, out_data.halted)
  `CLFPD_ASSERT_IMP(a_err_range, clk, rst_n, out_valid, (out_data.steer_error >= -8'sd100) && (out_data.steer_error <= 8'sd100))

endmodule

bind color_line_follow_pd_controller_top clfpd_checker u_clfpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color line follower PD controller testbench
// Drives sensor words through the valid/ready input channel with random gaps,
// stalls the motor word channel at random, and checks every motor word
// against an in-bench prediction of the classifier, the green-to-error map,
// the PD term and the blue stop latch. Register settings change between
// phases while the controller is idle, and the run ends in the latched stop.
// ----------------------------------------------------------------------------

module testbench;
  import clfpd_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 4;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_word_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic [5:0] gain_p;
  logic [5:0] gain_d;
  logic [7:0] base_duty;
  logic [7:0] max_duty;
  logic [7:0] blue_needed;
  int         last_error;
  int         blue_run;
  bit         stop_latched;

  out_word_t   pending_motor_words[$];
  int unsigned tx_idle_max     = 10;
  int unsigned rx_idle_max     = 10;
  int unsigned rx_stall        = 0;
  int unsigned words_sent      = 0;
  int unsigned words_checked   = 0;
  int unsigned halted_checked  = 0;
  int unsigned settings_loaded = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  color_line_follow_pd_controller_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_word_t window_low(logic [1:0] cls);
    case (cls)
      ClsBlack: return '{BlkRLo, BlkGLo, BlkBLo};
      ClsRed:   return '{RedRLo, RedGLo, RedBLo};
      default:  return '{BluRLo, BluGLo, BluBLo};
    endcase
  endfunction

  function automatic in_word_t window_high(logic [1:0] cls);
    case (cls)
      ClsBlack: return '{BlkRHi, BlkGHi, BlkBHi};
      ClsRed:   return '{RedRHi, RedGHi, RedBHi};
      default:  return '{BluRHi, BluGHi, BluBHi};
    endcase
  endfunction

  function automatic bit within_window(in_word_t w, logic [1:0] cls);
    in_word_t lo;
    in_word_t hi;
    lo = window_low(cls);
    hi = window_high(cls);
    return w.red_period >= lo.red_period && w.red_period <= hi.red_period &&
           w.green_period >= lo.green_period && w.green_period <= hi.green_period &&
           w.blue_period >= lo.blue_period && w.blue_period <= hi.blue_period;
  endfunction

  function automatic logic [1:0] classify_reading(in_word_t w);
    if (within_window(w, ClsBlack)) return ClsBlack;
    if (within_window(w, ClsRed)) return ClsRed;
    if (within_window(w, ClsBlue)) return ClsBlue;
    return ClsOther;
  endfunction

  function automatic out_word_t predict_motor_word(in_word_t w);
    out_word_t  o;
    logic [1:0] cls;
    int         err;
    int         pd;
    int         left;
    int         right;
    cls = classify_reading(w);
    o = '0;
    o.surface_class = cls;
    if (!stop_latched) begin
      if (cls == ClsBlue) begin
        if (blue_run < 255) blue_run++;
        if (blue_run >= int'(blue_needed)) stop_latched = 1'b1;
      end else begin
        blue_run = 0;
      end
    end
    if (stop_latched) begin
      o.halted = 1'b1;
      return o;
    end
    err = (int'(w.green_period) - int'(GreenOffset)) * -200 /
          ((cls == ClsRed) ? int'(DivRed) : int'(DivOther)) + 100;
    if (err > 100) err = 100;
    else if (err < -100) err = -100;
    pd = int'(gain_p) * err + int'(gain_d) * (err - last_error);
    left = (2 * int'(base_duty) - pd) / 2;
    right = (2 * int'(base_duty) + pd) / 2;
    if (left < 0) left = 0;
    else if (left > int'(max_duty)) left = int'(max_duty);
    if (right < 0) right = 0;
    else if (right > int'(max_duty)) right = int'(max_duty);
    last_error = err;
    o.left_speed = left[7:0];
    o.right_speed = right[7:0];
    o.steer_error = err[7:0];
    return o;
  endfunction

  function automatic in_word_t reading(int unsigned r, int unsigned g, int unsigned b);
    return '{PeriodW'(r), PeriodW'(g), PeriodW'(b)};
  endfunction

  function automatic in_word_t window_word(logic [1:0] cls);
    in_word_t lo;
    in_word_t hi;
    lo = window_low(cls);
    hi = window_high(cls);
    return reading($urandom_range(lo.red_period, hi.red_period),
                   $urandom_range(lo.green_period, hi.green_period),
                   $urandom_range(lo.blue_period, hi.blue_period));
  endfunction

  // One field is pushed just outside its window.
  function automatic in_word_t near_miss_word();
    logic [1:0] cls;
    in_word_t   lo;
    in_word_t   hi;
    in_word_t   w;
    bit         above;
    case ($urandom_range(0, 2))
      0:       cls = ClsBlack;
      1:       cls = ClsRed;
      default: cls = ClsBlue;
    endcase
    lo = window_low(cls);
    hi = window_high(cls);
    w = window_word(cls);
    above = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0:       w.red_period = above ? hi.red_period + 1'b1 : lo.red_period - 1'b1;
      1:       w.green_period = above ? hi.green_period + 1'b1 : lo.green_period - 1'b1;
      default: w.blue_period = above ? hi.blue_period + 1'b1 : lo.blue_period - 1'b1;
    endcase
    return w;
  endfunction

  // Unless any_blue is set, blue words are held back while one more would latch the stop.
  function automatic in_word_t random_word(bit any_blue);
    int unsigned pick;
    in_word_t    w;
    bit          blue_ok;
    blue_ok = any_blue || (blue_run + 1 < int'(blue_needed));
    pick = $urandom_range(0, 9);
    if (pick <= 2) return window_word(ClsBlack);
    if (pick <= 4) return window_word(ClsRed);
    if (pick <= 6 && blue_ok) return window_word(ClsBlue);
    if (pick == 7) return near_miss_word();
    w.red_period = PeriodW'($urandom);
    w.blue_period = PeriodW'($urandom);
    w.green_period = $urandom_range(0, 1) ? PeriodW'($urandom) : PeriodW'($urandom_range(0, 200));
    return w;
  endfunction

  task automatic compare_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic check_motor_word(input out_word_t got);
    out_word_t want;
    if (pending_motor_words.size() == 0) begin
      mismatches++;
      $display("%0t: motor word %h arrived with nothing expected", $time, got);
    end else begin
      want = pending_motor_words.pop_front();
      words_checked++;
      if (want.halted) halted_checked++;
      compare_field("left_speed", want.left_speed, got.left_speed);
      compare_field("right_speed", want.right_speed, got.right_speed);
      compare_field("halted", want.halted, got.halted);
      compare_field("surface_class", want.surface_class, got.surface_class);
      compare_field("steer_error", want.steer_error, got.steer_error);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      check_motor_word(out_data);
      rx_stall = $urandom_range(0, rx_idle_max);
    end else if (rx_stall != 0) begin
      rx_stall = rx_stall - 1;
    end
    out_ready <= rst_n && (rx_stall == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_reading(input in_word_t w);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_motor_words.push_back(predict_motor_word(w));
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_motor_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val,
                           input bit end_burst);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (end_burst) cfg_valid <= 1'b0;
    case (idx)
      CfgKp:      gain_p = val[5:0];
      CfgKd:      gain_d = val[5:0];
      CfgBase:    base_duty = val;
      CfgMax:     max_duty = val;
      CfgConfirm: blue_needed = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int unsigned kp, input int unsigned kd,
                               input int unsigned base, input int unsigned top,
                               input int unsigned confirm);
    write_reg(CfgKp, CfgDataW'(kp), 1'b0);
    write_reg(CfgKd, CfgDataW'(kd), 1'b0);
    write_reg(CfgBase, CfgDataW'(base), 1'b0);
    write_reg(CfgMax, CfgDataW'(top), 1'b0);
    write_reg(CfgConfirm, CfgDataW'(confirm), 1'b1);
    settings_loaded++;
  endtask

  task automatic test_default_readings();
    send_reading(window_low(ClsBlack));
    send_reading(window_high(ClsBlack));
    send_reading(window_low(ClsRed));
    send_reading(window_high(ClsRed));
    send_reading(reading(0, 0, 0));
    send_reading(reading(16383, 16383, 16383));
    send_reading(reading(10000, 18, 0));
    repeat (3) send_reading(window_word(ClsBlue));
    send_reading(window_low(ClsRed));
    send_reading(window_low(ClsBlue));
    send_reading(window_high(ClsBlue));
    repeat (2) send_reading(window_word(ClsBlue));
    send_reading(window_high(ClsBlack));
  endtask

  task automatic test_register_extremes();
    wait_for_results();
    load_settings(0, 0, 0, 0, 1);
    send_reading(window_low(ClsBlack));
    send_reading(window_high(ClsRed));
    send_reading(reading(0, 100, 0));
    wait_for_results();
    load_settings(63, 63, 255, 255, 255);
    send_reading(window_high(ClsBlack));
    send_reading(window_low(ClsRed));
    repeat (2) send_reading(window_word(ClsBlue));
    send_reading(reading(16383, 0, 16383));
    wait_for_results();
    // Gain writes keep only the low six bits; unused indexes change nothing.
    write_reg(CfgKp, 8'hC0, 1'b0);
    write_reg(CfgKd, 8'hFF, 1'b0);
    for (int i = int'(CfgConfirm) + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), 8'hFF, i == (1 << CfgIdxW) - 1);
    end
    send_reading(window_word(ClsRed));
    send_reading(reading(5000, 60, 5000));
  endtask

  task automatic test_random_track();
    for (int phase = 0; phase < 8; phase++) begin
      int unsigned confirm;
      case (phase % 3)
        0:       confirm = 255;
        1:       confirm = 1;
        default: confirm = $urandom_range(2, 8);
      endcase
      wait_for_results();
      load_settings($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255),
                    $urandom_range(0, 255), confirm);
      case (phase % 4)
        0: begin tx_idle_max = 10; rx_idle_max = 10; end
        1: begin tx_idle_max = 0;  rx_idle_max = 0;  end
        2: begin tx_idle_max = 10; rx_idle_max = 0;  end
        default: begin tx_idle_max = 0; rx_idle_max = 10; end
      endcase
      for (int i = 0; i < 60; i++) begin
        if (phase == 2 && i == 30) wait_for_results();
        send_reading(random_word(1'b0));
      end
    end
  endtask

  task automatic test_blue_stop();
    wait_for_results();
    tx_idle_max = 10;
    rx_idle_max = 10;
    write_reg(CfgConfirm, 8'd0, 1'b1);
    send_reading(window_word(ClsRed));
    send_reading(reading(0, 0, 0));
    send_reading(window_word(ClsBlue));
    repeat (20) send_reading(random_word(1'b1));
    wait_for_results();
    load_settings(63, 63, 255, 255, 5);
    repeat (5) send_reading(random_word(1'b1));
  endtask

  initial begin
    gain_p = KpReset;
    gain_d = KdReset;
    base_duty = BaseReset;
    max_duty = MaxReset;
    blue_needed = ConfirmReset;
    last_error = 0;
    blue_run = 0;
    stop_latched = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_default_readings();
    test_register_extremes();
    test_random_track();
    test_blue_stop();
    wait_for_results();
    $display("Sent %0d sensor words and checked %0d motor words, %0d of them after the stop.",
             words_sent, words_checked, halted_checked);
    $display("Went through %0d register settings with random gaps and stalls.",
             settings_loaded);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/clfpd_pkg.sv
hw/rtl/color_line_follow_pd_controller_top.sv
hw/rtl/clfpd_checker.sv
tb/testbench.sv
